// ===== design/bslp_pkg.sv =====
// Shared types and constants for the button short/long press detector.
// Depends on nothing; every design file imports it.
`timescale 1ns / 1ps

package bslp_pkg;

  localparam int ButtonCount = 3;
  localparam int MaskWidth   = 3;
  localparam int PeriodWidth = 12;
  localparam int TimerWidth  = 14;
  localparam int IndexWidth  = 2;
  localparam int CfgIdxWidth = 1;

  localparam logic [PeriodWidth-1:0] SHORT_PERIOD_RST = 12'd50;
  localparam logic [PeriodWidth-1:0] LONG_PERIOD_RST  = 12'd500;

  localparam logic signed [TimerWidth:0] TIMER_MAX = 15'sd8191;
  localparam logic signed [TimerWidth:0] TIMER_MIN = -15'sd8192;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [CfgIdxWidth-1:0] REG_SHORT_PERIOD = 1'd0;
  localparam logic [CfgIdxWidth-1:0] REG_LONG_PERIOD  = 1'd1;

  typedef struct packed {
    logic [MaskWidth-1:0]   pressed_mask;
    logic [PeriodWidth-1:0] elapsed_ms;
  } bslp_in_t;

  typedef struct packed {
    logic [1:0]            press_kind;
    logic [IndexWidth-1:0] button_index;
  } bslp_out_t;

  // Per-button report toward the priority pick.
  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } bslp_report_t;

endpackage

// ===== design/button_short_long_press_detector_unit.sv =====
// Top level of the button short/long press detector: input register, timer cells,
// priority pick and result register. Depends on bslp_pkg, bslp_cfg_regs, bslp_timer_cell.
`timescale 1ns / 1ps

// One poll request is taken per clock while the result is not stalled and gives exactly
// one result (input register, then result register); the timers update in the same cycle
// the poll moves into the result register, so consecutive polls run back to back. The
// result register is the only buffer toward the consumer, and a stalled output holds
// the input register in turn. Buttons are scanned from index 0; the first one that
// reports a press stops the scan and later timers keep their value for that poll.
// Period registers reset to 50 ms (short) and 500 ms (long) and take effect on the
// next poll that reaches the timers.
module button_short_long_press_detector_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bslp_pkg::bslp_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bslp_pkg::bslp_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [bslp_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [bslp_pkg::PeriodWidth-1:0] cfg_wdata
);
  import bslp_pkg::*;

  bslp_in_t               in_r;
  logic                   in_valid_r;
  bslp_out_t              out_r, out_nxt;
  logic                   out_valid_r;
  logic                   advance;
  logic [PeriodWidth-1:0] short_period, long_period;
  bslp_report_t           report [ButtonCount];
  logic [ButtonCount-1:0] upd_en;
  logic                   blocked;

  bslp_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .short_period (short_period),
    .long_period  (long_period)
  );

  for (genvar g = 0; g < ButtonCount; g++) begin : g_btn
    logic held;
    if (g < MaskWidth) begin : g_mask
      assign held = in_r.pressed_mask[g];
    end else begin : g_none
      assign held = 1'b0;
    end
    bslp_timer_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .held         (held),
      .delta        (in_r.elapsed_ms),
      .short_period (short_period),
      .long_period  (long_period),
      .upd_en       (upd_en[g]),
      .report       (report[g])
    );
  end

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // First reporting button wins; hold every timer after it.
  always_comb begin
    blocked = 1'b0;
    out_nxt = '{press_kind: KIND_NONE, button_index: '0};
    for (int i = 0; i < ButtonCount; i++) begin
      upd_en[i] = advance && !blocked;
      if (!blocked && report[i].hit) begin
        out_nxt.press_kind   = report[i].kind;
        out_nxt.button_index = IndexWidth'(i);
      end
      blocked = blocked || report[i].hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_none_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.press_kind == KIND_NONE) |-> out_r.button_index == '0)
    else $error("no-press result carries a nonzero button index");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.press_kind != KIND_BAD)
    else $error("illegal press kind on result");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> in_valid_r)
    else $error("accepted request lost before the timers");

  a_stall_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> upd_en == '0)
    else $error("timers updated while the result is stalled");
`endif

endmodule

// ===== design/bslp_timer_cell.sv =====
// One button's signed hold timer with its saturating update and period tests.
// Depends on bslp_pkg.
`timescale 1ns / 1ps

module bslp_timer_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            held,
  input  logic [bslp_pkg::PeriodWidth-1:0] delta,
  input  logic [bslp_pkg::PeriodWidth-1:0] short_period,
  input  logic [bslp_pkg::PeriodWidth-1:0] long_period,
  input  logic                            upd_en,
  output bslp_pkg::bslp_report_t           report
);
  import bslp_pkg::*;

  logic signed [TimerWidth-1:0] timer_r, timer_nxt;
  logic signed [TimerWidth:0]   t_ext, d_ext, sum, sat, lp_ext, sp_ext;
  logic                         long_hit, short_hit;

  always_comb begin
    t_ext  = {timer_r[TimerWidth-1], timer_r};
    d_ext  = $signed({{(TimerWidth+1-PeriodWidth){1'b0}}, delta});
    lp_ext = $signed({{(TimerWidth+1-PeriodWidth){1'b0}}, long_period});
    sp_ext = $signed({{(TimerWidth+1-PeriodWidth){1'b0}}, short_period});
    // grow magnitude, keeping the sign
    if (timer_r[TimerWidth-1]) begin
      sum = t_ext - d_ext;
      sat = (sum < TIMER_MIN) ? TIMER_MIN : sum;
    end else begin
      sum = t_ext + d_ext;
      sat = (sum > TIMER_MAX) ? TIMER_MAX : sum;
    end
    long_hit  = held && ((sat > lp_ext) || (sat < -lp_ext));
    short_hit = !held && (t_ext > sp_ext);

    report.hit  = long_hit || short_hit;
    report.kind = long_hit ? KIND_LONG : (short_hit ? KIND_SHORT : KIND_NONE);

    if (!held) begin
      timer_nxt = '0;
    end else if (long_hit) begin
      timer_nxt = '1;
    end else begin
      timer_nxt = sat[TimerWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
    end else if (upd_en) begin
      timer_r <= timer_nxt;
    end
  end

endmodule

// ===== design/bslp_cfg_regs.sv =====
// Period registers written through the plain configuration port.
// Depends on bslp_pkg.
`timescale 1ns / 1ps

module bslp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bslp_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [bslp_pkg::PeriodWidth-1:0] cfg_wdata,
  output logic [bslp_pkg::PeriodWidth-1:0] short_period,
  output logic [bslp_pkg::PeriodWidth-1:0] long_period
);
  import bslp_pkg::*;

  logic [PeriodWidth-1:0] short_period_r, long_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_period_r <= SHORT_PERIOD_RST;
      long_period_r  <= LONG_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_PERIOD: short_period_r <= cfg_wdata;
        REG_LONG_PERIOD:  long_period_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign short_period = short_period_r;
  assign long_period  = long_period_r;

endmodule

// ===== verif/button_short_long_press_detector_unit_test.sv =====
// Testbench for the button short/long press detector: directed and random polls,
// checked against a behavioral predictor of the per-button hold timers.
// Depends on bslp_pkg and button_short_long_press_detector_unit.
`timescale 1ns / 1ps

module button_short_long_press_detector_unit_test;
  import bslp_pkg::*;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  bslp_in_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  bslp_out_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = REG_SHORT_PERIOD;
  logic [PeriodWidth-1:0] cfg_wdata = '0;

  // Predictor state: hold timers and period registers as the block should hold them.
  int                     btn_timer [ButtonCount];
  logic [PeriodWidth-1:0] short_period_q = SHORT_PERIOD_RST;
  logic [PeriodWidth-1:0] long_period_q  = LONG_PERIOD_RST;
  bslp_out_t              press_q [$];
  bslp_out_t              want_press;

  int                     err_count  = 0;
  int                     tx_gap_max = 18;
  int                     rx_gap_max = 18;
  int                     rx_hold    = 0;
  logic [MaskWidth-1:0]   held_mask  = '0;

  always #1 clk = ~clk;

  button_short_long_press_detector_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  // Scan buttons from 0 upward; the first one that reports ends the scan.
  function automatic bslp_out_t predict_press(input bslp_in_t req);
    bslp_out_t res;
    int        t;
    int        delta;
    int        sp;
    int        lp;
    bit        held;
    res.press_kind   = KIND_NONE;
    res.button_index = '0;
    delta = int'(req.elapsed_ms);
    sp = int'(short_period_q);
    lp = int'(long_period_q);
    for (int i = 0; i < ButtonCount; i++) begin
      t = btn_timer[i];
      held = (i < MaskWidth) && req.pressed_mask[i];
      if (held) begin
        if (t < 0) begin
          t = t - delta;
          if (t < -8192) t = -8192;
        end else begin
          t = t + delta;
          if (t > 8191) t = 8191;
        end
        if (t > lp || t < -lp) begin
          btn_timer[i]     = -1;
          res.press_kind   = KIND_LONG;
          res.button_index = IndexWidth'(i);
          return res;
        end
        btn_timer[i] = t;
      end else begin
        btn_timer[i] = 0;
        if (t > sp) begin
          res.press_kind   = KIND_SHORT;
          res.button_index = IndexWidth'(i);
          return res;
        end
      end
    end
    return res;
  endfunction

  // Entered and left at a falling edge; valid stays high on return so that a
  // back-to-back request needs no second assignment in the same step.
  task automatic send_poll(input logic [MaskWidth-1:0] mask,
                           input logic [PeriodWidth-1:0] ms);
    bslp_in_t req;
    int       gap;
    req.pressed_mask = mask;
    req.elapsed_ms   = ms;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    press_q.push_back(predict_press(req));
    @(negedge clk);
  endtask

  // Drop valid at once, then hold until every request has its result.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (press_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_periods(input logic [PeriodWidth-1:0] sp,
                             input logic [PeriodWidth-1:0] lp);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHORT_PERIOD;
    cfg_wdata <= sp;
    @(negedge clk);
    cfg_index <= REG_LONG_PERIOD;
    cfg_wdata <= lp;
    @(negedge clk);
    cfg_we <= 1'b0;
    short_period_q = sp;
    long_period_q  = lp;
    @(negedge clk);
  endtask

  // Masks mostly persist so timers build up across polls; elapsed times lean
  // toward fractions of the current periods.
  task automatic run_random_polls(input int count);
    int ms;
    int lim;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) >= 8) held_mask = MaskWidth'($urandom_range(0, 7));
      lim = int'(long_period_q) / 3 + 1;
      case ($urandom_range(0, 5))
        0:       ms = 0;
        1:       ms = $urandom_range(3500, 4095);
        2, 3:    ms = $urandom_range(0, lim);
        4:       ms = $urandom_range(0, int'(short_period_q) / 2 + 1);
        default: ms = $urandom_range(0, 4095);
      endcase
      send_poll(held_mask, PeriodWidth'(ms));
    end
  endtask

  task automatic test_directed_polls();
    set_periods(SHORT_PERIOD_RST, LONG_PERIOD_RST);
    send_poll(3'b000, 12'd0);
    send_poll(3'b111, 12'd4095);
    send_poll(3'b111, 12'd0);
    send_poll(3'b000, 12'd0);
    // release exactly at the short period, then just above it
    send_poll(3'b010, 12'd30);
    send_poll(3'b010, 12'd20);
    send_poll(3'b000, 12'd0);
    send_poll(3'b010, 12'd51);
    send_poll(3'b000, 12'd7);
    // long press at the boundary, then repeat while held
    send_poll(3'b100, 12'd300);
    send_poll(3'b100, 12'd200);
    send_poll(3'b100, 12'd1);
    send_poll(3'b100, 12'd499);
    send_poll(3'b100, 12'd1);
    // two reports in one poll: the lower index wins, the other waits
    send_poll(3'b101, 12'd100);
    send_poll(3'b001, 12'd0);
    send_poll(3'b101, 12'd60);
    send_poll(3'b000, 12'd0);
    send_poll(3'b000, 12'd0);
    send_poll(3'b110, 12'd4095);
    send_poll(3'b011, 12'd4095);
    // zero periods: zero elapsed time still repeats a long press
    set_periods(12'd0, 12'd0);
    send_poll(3'b001, 12'd0);
    send_poll(3'b010, 12'd0);
    send_poll(3'b100, 12'd1);
    send_poll(3'b100, 12'd0);
    send_poll(3'b000, 12'd0);
  endtask

  task automatic test_period_extremes();
    set_periods(12'd0, 12'd4095);
    run_random_polls(60);
    set_periods(12'd4095, 12'd4095);
    run_random_polls(60);
    set_periods(12'd4095, 12'd0);
    run_random_polls(60);
    set_periods(12'd0, 12'd0);
    run_random_polls(60);
  endtask

  task automatic test_random_polls();
    for (int p = 0; p < 6; p++) begin
      if (p % 2 == 0) begin
        set_periods(PeriodWidth'($urandom_range(0, 200)), PeriodWidth'($urandom_range(0, 1500)));
      end else begin
        set_periods(PeriodWidth'($urandom_range(0, 4095)), PeriodWidth'($urandom_range(0, 4095)));
      end
      case (p % 3)
        0: begin
          tx_gap_max = 18;
          rx_gap_max = 18;
        end
        1: begin
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        default: begin
          tx_gap_max = 0;
          rx_gap_max = 18;
        end
      endcase
      run_random_polls(220);
    end
    tx_gap_max = 18;
    rx_gap_max = 18;
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_output_stall();
    set_periods(SHORT_PERIOD_RST, LONG_PERIOD_RST);
    tx_gap_max = 0;
    rx_hold = 200;
    run_random_polls(100);
    tx_gap_max = 18;
  endtask

  task automatic test_sender_pause();
    run_random_polls(30);
    wait_drain();
    run_random_polls(30);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (press_q.size() == 0) begin
        report_mismatch("result with no request pending", int'(out_data), 0);
      end else begin
        want_press = press_q.pop_front();
        if (out_data.press_kind !== want_press.press_kind)
          report_mismatch("press_kind", int'(out_data.press_kind),
                          int'(want_press.press_kind));
        if (out_data.button_index !== want_press.button_index)
          report_mismatch("button_index", int'(out_data.button_index),
                          int'(want_press.button_index));
      end
    end
  end

  initial begin
    int wait_n;
    @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        wait_n  = rx_hold;
        rx_hold = 0;
      end else begin
        wait_n = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
      @(negedge clk);
    end
  end

  initial begin
    for (int i = 0; i < ButtonCount; i++) btn_timer[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_polls();
    test_period_extremes();
    test_random_polls();
    test_output_stall();
    test_sender_pause();
    wait_drain();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
